### rtl/afrb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ADC frame ring buffer.
// Used by every module of the block; depends on nothing.
package afrb_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int STAMP_W     = 32;
    localparam int COUNT_W     = 32;
    localparam int USED_W      = 7;
    localparam int LEVEL_W     = 8;
    localparam int SLOT_MAX_W  = 8;
    localparam int INDEX_MAX_W = 7;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USED   = 4'd1;
    localparam logic [USED_W-1:0]    USED_RESET = 7'd32;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_FRAME = 2'd0,
        ST_EMPTY = 2'd1,
        ST_CLEAR = 2'd2
    } t_status;

    typedef struct packed {
        t_req_type             req_type;
        logic [SAMPLE_W-1:0]   sample;
        logic                  frame_end;
        logic [STAMP_W-1:0]    time_ms;
    } t_req;

    typedef struct packed {
        t_status               status;
        logic [SAMPLE_W-1:0]   word;
        logic                  last;
        logic [STAMP_W-1:0]    frame_time;
        logic [COUNT_W-1:0]    frame_number;
        logic [USED_W-1:0]     used_words_out;
        logic [LEVEL_W-1:0]    level;
        logic                  full_res;
        logic [COUNT_W-1:0]    total_frames;
        logic [COUNT_W-1:0]    lost_frames;
    } t_res;

    // Write port of the sample and metadata stores, driven by the front end.
    typedef struct packed {
        logic                   word_we;
        logic                   meta_we;
        logic [SLOT_MAX_W-1:0]  slot;
        logic [INDEX_MAX_W-1:0] index;
        logic [SAMPLE_W-1:0]    sample;
        logic [STAMP_W-1:0]     stamp;
        logic [COUNT_W-1:0]     seq;
    } t_mem_wr;

    // One queued job for the back end, with the statistics taken after its request.
    typedef struct packed {
        t_status               status;
        logic [SLOT_MAX_W-1:0] slot;
        logic [LEVEL_W-1:0]    level;
        logic                  full_res;
        logic [COUNT_W-1:0]    total_frames;
        logic [COUNT_W-1:0]    lost_frames;
    } t_cmd;

endpackage

### rtl/adc_frame_ring_buffer_top.sv
`timescale 1ns / 1ps
// ADC frame ring buffer, top level: front end, job queue and back end.
// Depends on afrb_pkg, afrb_front, afrb_queue and afrb_back.
// A push word is taken while busy is low and does not raise busy, so samples can stream in
// one per cycle while no read or clear is running. A read or clear word raises busy for its
// whole run: a frame read gives one result word per cycle on consecutive cycles, paced by
// the single read port of the sample store; an empty read or a clear gives one word.
// Each result is valid for exactly one cycle and the receiver cannot stall it.
// Configuration writes are always ready and take effect on the next cycle.
module adc_frame_ring_buffer_top #(
    parameter int FRAME_WORDS = 32,
    parameter int SLOTS       = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  afrb_pkg::t_req                     i_req,
    output logic                               o_res_valid,
    output afrb_pkg::t_res                     o_res,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [afrb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [afrb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic                          accept;
    logic                          cmd_push;
    logic                          cmd_pop;
    logic                          queue_empty;
    logic                          back_busy;
    logic [afrb_pkg::USED_W-1:0]   used_words;
    afrb_pkg::t_mem_wr             mem_wr;
    afrb_pkg::t_cmd                cmd_in;
    afrb_pkg::t_cmd                cmd_out;

    assign accept      = start && !busy;
    assign busy        = back_busy || !queue_empty;
    assign o_cfg_ready = 1'b1;

    afrb_front #(
        .FRAME_WORDS (FRAME_WORDS),
        .SLOTS       (SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_req        (i_req),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_used_words (used_words),
        .o_mem_wr     (mem_wr),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    afrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (queue_empty)
    );

    afrb_back #(
        .FRAME_WORDS (FRAME_WORDS),
        .SLOTS       (SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mem_wr     (mem_wr),
        .i_cmd_valid  (!queue_empty),
        .i_cmd        (cmd_out),
        .i_used_words (used_words),
        .o_cmd_pop    (cmd_pop),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res),
        .o_busy       (back_busy)
    );

endmodule

### rtl/afrb_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, ring pointers, counters and request decode.
// Depends on afrb_pkg.
module afrb_front #(
    parameter int FRAME_WORDS = 32,
    parameter int SLOTS       = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  afrb_pkg::t_req                     i_req,
    input  logic                               i_cfg_we,
    input  logic [afrb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [afrb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [afrb_pkg::USED_W-1:0]        o_used_words,
    output afrb_pkg::t_mem_wr                  o_mem_wr,
    output logic                               o_cmd_push,
    output afrb_pkg::t_cmd                     o_cmd
);

    localparam int SW     = $clog2(SLOTS);
    localparam int FILL_W = $clog2(FRAME_WORDS + 1);

    logic [SW-1:0]                   r_wr_slot, n_wr_slot;
    logic [SW-1:0]                   r_rd_slot, n_rd_slot;
    logic [FILL_W-1:0]               r_fill, n_fill;
    logic [afrb_pkg::COUNT_W-1:0]    r_acq, n_acq;
    logic [afrb_pkg::COUNT_W-1:0]    r_lost, n_lost;
    logic                            r_policy;
    logic [afrb_pkg::USED_W-1:0]     r_used;

    logic [SW-1:0]                   wr_next;
    logic [SW-1:0]                   rd_next;
    logic                            ring_empty;
    logic                            ring_full;
    logic [SW:0]                     level_now;

    assign wr_next    = (r_wr_slot == SW'(SLOTS - 1)) ? '0 : r_wr_slot + 1'b1;
    assign rd_next    = (r_rd_slot == SW'(SLOTS - 1)) ? '0 : r_rd_slot + 1'b1;
    assign ring_empty = (r_wr_slot == r_rd_slot);
    assign ring_full  = (wr_next == r_rd_slot);

    always_comb begin
        level_now = {1'b0, r_wr_slot} - {1'b0, r_rd_slot};
        if (r_wr_slot < r_rd_slot) begin
            level_now = level_now + (SW + 1)'(SLOTS);
        end
    end

    always_comb begin
        n_wr_slot  = r_wr_slot;
        n_rd_slot  = r_rd_slot;
        n_fill     = r_fill;
        n_acq      = r_acq;
        n_lost     = r_lost;
        o_mem_wr   = '0;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        o_mem_wr.slot   = afrb_pkg::SLOT_MAX_W'(r_wr_slot);
        o_mem_wr.index  = afrb_pkg::INDEX_MAX_W'(r_fill);
        o_mem_wr.sample = i_req.sample;
        o_mem_wr.stamp  = i_req.time_ms;
        o_mem_wr.seq    = r_acq;
        // A result always follows a read or a clear, neither of which leaves the ring full.
        o_cmd.full_res     = 1'b0;
        o_cmd.total_frames = r_acq;
        o_cmd.lost_frames  = r_lost;
        if (i_accept) begin
            unique case (i_req.req_type)
                afrb_pkg::REQ_PUSH: begin
                    if (r_fill < FILL_W'(FRAME_WORDS)) begin
                        o_mem_wr.word_we = 1'b1;
                        n_fill           = r_fill + 1'b1;
                    end
                    if (i_req.frame_end) begin
                        n_fill = '0;
                        n_acq  = r_acq + 1'b1;
                        if (ring_full) begin
                            n_lost = r_lost + 1'b1;
                        end
                        if (!(ring_full && r_policy)) begin
                            if (ring_full) begin
                                n_rd_slot = rd_next;
                            end
                            o_mem_wr.meta_we = 1'b1;
                            n_wr_slot        = wr_next;
                        end
                    end
                end
                afrb_pkg::REQ_READ: begin
                    o_cmd_push = 1'b1;
                    if (ring_empty) begin
                        o_cmd.status = afrb_pkg::ST_EMPTY;
                        o_cmd.level  = '0;
                    end else begin
                        o_cmd.status = afrb_pkg::ST_FRAME;
                        o_cmd.slot   = afrb_pkg::SLOT_MAX_W'(r_rd_slot);
                        o_cmd.level  = afrb_pkg::LEVEL_W'(level_now - 1'b1);
                        n_rd_slot    = rd_next;
                    end
                end
                afrb_pkg::REQ_CLEAR: begin
                    n_wr_slot          = '0;
                    n_rd_slot          = '0;
                    n_fill             = '0;
                    n_acq              = '0;
                    n_lost             = '0;
                    o_cmd_push         = 1'b1;
                    o_cmd.status       = afrb_pkg::ST_CLEAR;
                    o_cmd.level        = '0;
                    o_cmd.total_frames = '0;
                    o_cmd.lost_frames  = '0;
                end
                afrb_pkg::REQ_NONE: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot <= '0;
            r_rd_slot <= '0;
            r_fill    <= '0;
            r_acq     <= '0;
            r_lost    <= '0;
            r_policy  <= 1'b0;
            r_used    <= afrb_pkg::USED_RESET;
        end else begin
            r_wr_slot <= n_wr_slot;
            r_rd_slot <= n_rd_slot;
            r_fill    <= n_fill;
            r_acq     <= n_acq;
            r_lost    <= n_lost;
            if (i_cfg_we && (i_cfg_index == afrb_pkg::CFG_POLICY)) begin
                r_policy <= i_cfg_data[0];
            end
            if (i_cfg_we && (i_cfg_index == afrb_pkg::CFG_USED)) begin
                r_used <= i_cfg_data[afrb_pkg::USED_W-1:0];
            end
        end
    end

    assign o_used_words = r_used;

endmodule

### rtl/afrb_queue.sv
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the back end.
// Depends on afrb_pkg.
module afrb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  afrb_pkg::t_cmd   i_data,
    input  logic             i_pop,
    output afrb_pkg::t_cmd   o_data,
    output logic             o_empty
);

    afrb_pkg::t_cmd  r_entry [2];
    logic            r_head, n_head;
    logic            r_tail, n_tail;
    logic [1:0]      r_count, n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail = ~r_tail;
        end
        if (i_pop) begin
            n_head = ~r_head;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_tail] <= i_data;
        end
    end

    assign o_data  = r_entry[r_head];
    assign o_empty = (r_count == '0);

endmodule

### rtl/afrb_back.sv
`timescale 1ns / 1ps
// Back end: sample and metadata stores and the sequencer that emits result words.
// Depends on afrb_pkg.
module afrb_back #(
    parameter int FRAME_WORDS = 32,
    parameter int SLOTS       = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  afrb_pkg::t_mem_wr             i_mem_wr,
    input  logic                          i_cmd_valid,
    input  afrb_pkg::t_cmd                i_cmd,
    input  logic [afrb_pkg::USED_W-1:0]   i_used_words,
    output logic                          o_cmd_pop,
    output logic                          o_res_valid,
    output afrb_pkg::t_res                o_res,
    output logic                          o_busy
);

    localparam int SW    = $clog2(SLOTS);
    localparam int DEPTH = SLOTS * FRAME_WORDS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(FRAME_WORDS);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_EMIT = 2'b10
    } t_back_state;

    logic [afrb_pkg::SAMPLE_W-1:0] r_frame_mem [DEPTH];
    logic [afrb_pkg::STAMP_W-1:0]  r_stamp_mem [SLOTS];
    logic [afrb_pkg::COUNT_W-1:0]  r_seq_mem   [SLOTS];

    t_back_state                   r_state, n_state;
    logic [LW-1:0]                 r_left, n_left;
    logic [AW-1:0]                 r_addr, n_addr;
    afrb_pkg::t_cmd                r_cmd;
    logic [afrb_pkg::SAMPLE_W-1:0] r_word_q;
    logic [afrb_pkg::STAMP_W-1:0]  r_stamp_q;
    logic [afrb_pkg::COUNT_W-1:0]  r_seq_q;

    logic                          pop;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 base_addr;
    logic                          is_frame;

    assign wr_addr   = AW'(i_mem_wr.slot[SW-1:0]) * AW'(FRAME_WORDS) + AW'(i_mem_wr.index);
    assign base_addr = AW'(i_cmd.slot[SW-1:0]) * AW'(FRAME_WORDS);
    assign pop       = (r_state == BK_IDLE) && i_cmd_valid;
    assign rd_en     = pop || ((r_state == BK_EMIT) && (r_left != '0));
    assign rd_addr   = pop ? base_addr : r_addr;

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        n_addr  = r_addr;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = BK_EMIT;
                    n_addr  = base_addr + 1'b1;
                    n_left  = (i_cmd.status == afrb_pkg::ST_FRAME) ? LW'(FRAME_WORDS - 1) : '0;
                end
            end
            BK_EMIT: begin
                if (r_left == '0) begin
                    n_state = BK_IDLE;
                end else begin
                    n_left = r_left - 1'b1;
                    n_addr = r_addr + 1'b1;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_left  <= '0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.word_we) begin
            r_frame_mem[wr_addr] <= i_mem_wr.sample;
        end
        if (i_mem_wr.meta_we) begin
            r_stamp_mem[i_mem_wr.slot[SW-1:0]] <= i_mem_wr.stamp;
            r_seq_mem[i_mem_wr.slot[SW-1:0]]   <= i_mem_wr.seq;
        end
        if (rd_en) begin
            r_word_q <= r_frame_mem[rd_addr];
        end
        if (pop) begin
            r_cmd     <= i_cmd;
            r_stamp_q <= r_stamp_mem[i_cmd.slot[SW-1:0]];
            r_seq_q   <= r_seq_mem[i_cmd.slot[SW-1:0]];
        end
    end

    assign is_frame    = (r_cmd.status == afrb_pkg::ST_FRAME);
    assign o_cmd_pop   = pop;
    assign o_res_valid = (r_state == BK_EMIT);
    assign o_busy      = (r_state != BK_IDLE);

    always_comb begin
        o_res.status         = r_cmd.status;
        o_res.word           = is_frame ? r_word_q : '0;
        o_res.last           = (r_left == '0);
        o_res.frame_time     = is_frame ? r_stamp_q : '0;
        o_res.frame_number   = is_frame ? r_seq_q : '0;
        o_res.used_words_out = i_used_words;
        o_res.level          = r_cmd.level;
        o_res.full_res       = r_cmd.full_res;
        o_res.total_frames   = r_cmd.total_frames;
        o_res.lost_frames    = r_cmd.lost_frames;
    end

endmodule

### rtl/afrb_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the ADC frame ring buffer, bound to the top level.
// Depends on afrb_pkg and adc_frame_ring_buffer_top.
module afrb_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic            busy,
    input  afrb_pkg::t_req  i_req,
    input  logic            o_res_valid,
    input  afrb_pkg::t_res  o_res
);

    a_res_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> busy)
        else $error("result word shown while not busy");

    a_read_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.req_type == afrb_pkg::REQ_READ)) |=> busy)
        else $error("read word accepted without raising busy");

    a_frame_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |=> o_res_valid)
        else $error("gap inside a frame read");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |=> !o_res_valid)
        else $error("result word right after the last one");

    a_single_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != afrb_pkg::ST_FRAME)) |-> o_res.last)
        else $error("status word not marked last");

endmodule

bind adc_frame_ring_buffer_top afrb_checker u_afrb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req       (i_req),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);
